@@ rtl/udpfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpfr_pkg: shared types and constants of the UDP/IPv4/Ethernet framer
// Payload structs, command queue entry, configuration bundle, header constants.
// ----------------------------------------------------------------------------
package udpfr_pkg;

  localparam int HDR_BYTES       = 42;
  localparam int IPUDP_HDR_BYTES = 28;
  localparam int UDP_HDR_BYTES   = 8;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);

  localparam logic [7:0]  ETHERTYPE_HI = 8'h08;
  localparam logic [7:0]  ETHERTYPE_LO = 8'h00;
  localparam logic [3:0]  IP_VER       = 4'd4;
  localparam logic [3:0]  IP_IHL       = 4'd5;
  localparam logic [7:0]  IP_TTL       = 8'd128;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;

  // configuration register index (paddr[5:3])
  typedef enum logic [2:0] {
    REG_SRC_MAC  = 3'd0,
    REG_DST_MAC  = 3'd1,
    REG_SRC_IP   = 3'd2,
    REG_DST_IP   = 3'd3,
    REG_SRC_PORT = 3'd4,
    REG_DST_PORT = 3'd5
  } reg_idx_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_code_t;

  typedef struct packed {
    logic        cmd;
    logic [10:0] payload_len;
    logic [7:0]  payload_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       run_last;
    logic       frame_last;
  } out_t;

  // entry of the queue between front and back
  typedef struct packed {
    logic        is_hdr;
    logic [10:0] len;
    logic [7:0]  pbyte;
    logic        flast;
  } qent_t;

  typedef struct packed {
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/udp_ipv4_ethernet_framer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_ipv4_ethernet_framer_unit: UDP/IPv4/Ethernet II transmit framer
// Top level: APB register file, input classifier, command queue, sequencer.
// ----------------------------------------------------------------------------
// A start transfer (cmd 0) with a payload length up to MTU_BYTES - 28 produces
// the 42 header bytes of the frame, one per cycle while out_ready holds; a
// data transfer (cmd 1) inside an open frame produces its byte, so payload
// streams at one byte per cycle while out_ready holds; the byte sequencer
// sets this rate. The input side keeps accepting while a 4-entry command queue
// has room, so a header being sent only stalls the input once the queue fills.
// Over-limit starts and data outside a frame produce nothing. Registers sit
// at byte address 8*index and must be written while the framer is idle.
// ----------------------------------------------------------------------------
module udp_ipv4_ethernet_framer_unit #(
  parameter int MTU_BYTES = 1500
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_ready,
  input  udpfr_pkg::in_t  in_data,
  output logic            out_valid,
  input  wire             out_ready,
  output udpfr_pkg::out_t out_data,
  input  wire             psel,
  input  wire             penable,
  input  wire             pwrite,
  input  wire [5:0]       paddr,
  input  wire [63:0]      pwdata,
  output logic [63:0]     prdata,
  output logic            pready
);
  import udpfr_pkg::*;

  logic [47:0] src_mac_r, dst_mac_r;
  logic [31:0] src_ip_r, dst_ip_r;
  logic [15:0] src_port_r, dst_port_r;
  logic        wr_en;
  reg_idx_t    reg_sel;
  cfg_t        cfg;

  logic  q_push, q_pop, q_full, q_not_empty;
  qent_t q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_mac_r  <= '0;
      dst_mac_r  <= '1;
      src_ip_r   <= '0;
      dst_ip_r   <= '1;
      src_port_r <= '0;
      dst_port_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SRC_MAC:  src_mac_r  <= pwdata[47:0];
        REG_DST_MAC:  dst_mac_r  <= pwdata[47:0];
        REG_SRC_IP:   src_ip_r   <= pwdata[31:0];
        REG_DST_IP:   dst_ip_r   <= pwdata[31:0];
        REG_SRC_PORT: src_port_r <= pwdata[15:0];
        REG_DST_PORT: dst_port_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SRC_MAC:  prdata = 64'(src_mac_r);
      REG_DST_MAC:  prdata = 64'(dst_mac_r);
      REG_SRC_IP:   prdata = 64'(src_ip_r);
      REG_DST_IP:   prdata = 64'(dst_ip_r);
      REG_SRC_PORT: prdata = 64'(src_port_r);
      REG_DST_PORT: prdata = 64'(dst_port_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg.src_mac  = src_mac_r;
  assign cfg.dst_mac  = dst_mac_r;
  assign cfg.src_ip   = src_ip_r;
  assign cfg.dst_ip   = dst_ip_r;
  assign cfg.src_port = src_port_r;
  assign cfg.dst_port = dst_port_r;

  udpfr_front #(
    .MTU_BYTES (MTU_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  udpfr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  udpfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

@@ rtl/udpfr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpfr_front: input classifier
// Tracks the open frame, drops data outside a frame and over-limit starts,
// and pushes header and payload commands into the queue.
// ----------------------------------------------------------------------------
module udpfr_front #(
  parameter int MTU_BYTES = 1500
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  udpfr_pkg::in_t   in_data,
  input  wire              q_full,
  output logic             q_push,
  output udpfr_pkg::qent_t q_wdata
);
  import udpfr_pkg::*;

  localparam int LEN_LIMIT = MTU_BYTES - IPUDP_HDR_BYTES;

  logic [10:0] bytes_left_r, bytes_left_nxt;
  logic        frame_open_r, frame_open_nxt;
  logic        xfer;

  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    frame_open_nxt = frame_open_r;
    q_push         = 1'b0;
    q_wdata.is_hdr = (in_data.cmd == CMD_START);
    q_wdata.len    = in_data.payload_len;
    q_wdata.pbyte  = in_data.payload_byte;
    q_wdata.flast  = (in_data.payload_len == 11'd0);
    if (xfer) begin
      if (in_data.cmd == CMD_START) begin
        if (in_data.payload_len <= 11'(LEN_LIMIT)) begin
          q_push         = 1'b1;
          bytes_left_nxt = in_data.payload_len;
          frame_open_nxt = (in_data.payload_len != 11'd0);
        end
      end else if (frame_open_r && bytes_left_r != 11'd0) begin
        q_push         = 1'b1;
        q_wdata.flast  = (bytes_left_r == 11'd1);
        bytes_left_nxt = bytes_left_r - 11'd1;
        frame_open_nxt = (bytes_left_r != 11'd1);
      end else begin
        frame_open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      frame_open_r <= 1'b0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      frame_open_r <= frame_open_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/udpfr_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpfr_fifo: command queue
// Short queue that decouples the classifier from the byte sequencer.
// ----------------------------------------------------------------------------
module udpfr_fifo (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  udpfr_pkg::qent_t wdata,
  output logic             full,
  input  wire              pop,
  output logic             not_empty,
  output udpfr_pkg::qent_t rdata
);
  import udpfr_pkg::*;

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/udpfr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpfr_back: byte sequencer
// Steps through the 42 header bytes of a start command, passes payload bytes,
// builds the IPv4 header checksum one word per header byte, and drives the
// registered output channel.
// ----------------------------------------------------------------------------
module udpfr_back (
  input  wire              clk,
  input  wire              rst_n,
  input  udpfr_pkg::cfg_t  cfg,
  input  wire              q_not_empty,
  input  udpfr_pkg::qent_t q_rdata,
  output logic             q_pop,
  output logic             out_valid,
  input  wire              out_ready,
  output udpfr_pkg::out_t  out_data
);
  import udpfr_pkg::*;

  localparam logic [5:0]  LAST_IDX = 6'(HDR_BYTES - 1);
  // fixed words of the IPv4 header sum: version/IHL/TOS and TTL/protocol
  localparam logic [18:0] SUM_FIXED = 19'({IP_VER, IP_IHL, 8'h00}) +
                                      19'({IP_TTL, PROTO_UDP});

  logic        busy_r, busy_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [10:0] len_r, len_nxt;
  logic [18:0] sum_r, sum_nxt;
  logic        ovld_r, ovld_nxt;
  out_t        odat_r, odat_nxt;
  logic        out_free;
  logic [15:0] tot_len, udp_len, csum;

  assign out_free  = !ovld_r || out_ready;
  assign out_valid = ovld_r;
  assign out_data  = odat_r;
  assign tot_len   = 16'(len_r) + 16'(IPUDP_HDR_BYTES);
  assign udp_len   = 16'(len_r) + 16'(UDP_HDR_BYTES);
  assign csum      = ~sum_r[15:0];
  assign q_pop     = q_not_empty && !busy_r && out_free;

  function automatic logic [7:0] hdr_byte(input logic [5:0] i, input cfg_t c,
                                          input logic [15:0] tl,
                                          input logic [15:0] ul,
                                          input logic [15:0] cs);
    logic [7:0] b;
    b = 8'h00;
    case (i)
      6'd0:  b = c.dst_mac[47:40];
      6'd1:  b = c.dst_mac[39:32];
      6'd2:  b = c.dst_mac[31:24];
      6'd3:  b = c.dst_mac[23:16];
      6'd4:  b = c.dst_mac[15:8];
      6'd5:  b = c.dst_mac[7:0];
      6'd6:  b = c.src_mac[47:40];
      6'd7:  b = c.src_mac[39:32];
      6'd8:  b = c.src_mac[31:24];
      6'd9:  b = c.src_mac[23:16];
      6'd10: b = c.src_mac[15:8];
      6'd11: b = c.src_mac[7:0];
      6'd12: b = ETHERTYPE_HI;
      6'd13: b = ETHERTYPE_LO;
      6'd14: b = {IP_VER, IP_IHL};
      6'd16: b = tl[15:8];
      6'd17: b = tl[7:0];
      6'd22: b = IP_TTL;
      6'd23: b = PROTO_UDP;
      6'd24: b = cs[15:8];
      6'd25: b = cs[7:0];
      6'd26: b = c.src_ip[31:24];
      6'd27: b = c.src_ip[23:16];
      6'd28: b = c.src_ip[15:8];
      6'd29: b = c.src_ip[7:0];
      6'd30: b = c.dst_ip[31:24];
      6'd31: b = c.dst_ip[23:16];
      6'd32: b = c.dst_ip[15:8];
      6'd33: b = c.dst_ip[7:0];
      6'd34: b = c.src_port[15:8];
      6'd35: b = c.src_port[7:0];
      6'd36: b = c.dst_port[15:8];
      6'd37: b = c.dst_port[7:0];
      6'd38: b = ul[15:8];
      6'd39: b = ul[7:0];
      default: b = 8'h00;  // TOS, id, fragment, UDP checksum
    endcase
    return b;
  endfunction

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    len_nxt  = len_r;
    sum_nxt  = sum_r;
    ovld_nxt = ovld_r;
    odat_nxt = odat_r;
    if (busy_r && out_free) begin
      ovld_nxt            = 1'b1;
      odat_nxt.frame_byte = hdr_byte(idx_r, cfg, tot_len, udp_len, csum);
      odat_nxt.run_last   = (idx_r == LAST_IDX);
      odat_nxt.frame_last = (idx_r == LAST_IDX) && (len_r == 11'd0);
      idx_nxt             = idx_r + 6'd1;
      if (idx_r == LAST_IDX) busy_nxt = 1'b0;
      // checksum: one address word per step, then two carry folds
      case (idx_r)
        6'd1:    sum_nxt = sum_r + 19'(cfg.src_ip[31:16]);
        6'd2:    sum_nxt = sum_r + 19'(cfg.src_ip[15:0]);
        6'd3:    sum_nxt = sum_r + 19'(cfg.dst_ip[31:16]);
        6'd4:    sum_nxt = sum_r + 19'(cfg.dst_ip[15:0]);
        6'd5,
        6'd6:    sum_nxt = 19'(sum_r[15:0]) + 19'(sum_r[18:16]);
        default: sum_nxt = sum_r;
      endcase
    end else if (q_pop) begin
      ovld_nxt = 1'b1;
      if (q_rdata.is_hdr) begin
        busy_nxt            = 1'b1;
        idx_nxt             = 6'd1;
        len_nxt             = q_rdata.len;
        sum_nxt             = SUM_FIXED + 19'(q_rdata.len) + 19'(IPUDP_HDR_BYTES);
        odat_nxt.frame_byte = cfg.dst_mac[47:40];
        odat_nxt.run_last   = 1'b0;
        odat_nxt.frame_last = 1'b0;
      end else begin
        odat_nxt.frame_byte = q_rdata.pbyte;
        odat_nxt.run_last   = 1'b1;
        odat_nxt.frame_last = q_rdata.flast;
      end
    end else if (out_ready) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    sum_r  <= sum_nxt;
    odat_r <= odat_nxt;
  end

endmodule
`default_nettype wire
